### rtl/bounded_double_ended_queue_core_assert.svh
// Assertion macros for the deque core.
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked check, off while reset is high.
`define BDQ_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("deque core check failed");
// Clocked check, also live during reset.
`define BDQ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("deque core check failed");
`else
`define BDQ_ASSERT(lbl, clk, rst, prop)
`define BDQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### rtl/bdq_pkg.sv
package bdq_pkg;

  localparam int DATA_W = 32;
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // byte address of the capacity register
  localparam logic [1:0] ADDR_CAPACITY = 2'd0;

  typedef enum logic [1:0] {
    ACT_PUSH_LEFT  = 2'd0,
    ACT_PUSH_RIGHT = 2'd1,
    ACT_POP_LEFT   = 2'd2,
    ACT_POP_RIGHT  = 2'd3
  } bdq_action_t;

  typedef enum logic [1:0] {
    ST_PUSHED = 2'd0,
    ST_POPPED = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } bdq_status_t;

  // Broadcast to every cell; only set for a request that succeeds.
  typedef struct packed {
    logic push_left;
    logic push_right;
    logic pop_left;
  } bdq_op_t;

endpackage

### rtl/bounded_double_ended_queue_core.sv
// Bounded deque of signed 32-bit words held in a row of DEPTH cells, left
// aligned: cell 0 is the left end, cell count-1 the right end. Requests
// arrive on the s_ stream (s_tuser = action, s_tdata = push value) and each
// gives exactly one result transaction on the m_ stream (status, end, value).
// One transaction is taken per clock cycle as long as the output register is
// free or being drained; each result is registered, valid in the cycle after
// its request is taken. The longest path is the pop-right select, an OR over
// the DEPTH cell taps. The capacity register (APB, byte address 0, reset 16)
// limits the fill level, saturating at DEPTH; lowering it below the current
// count keeps the held words. No clearing pass is needed after reset.
`include "bounded_double_ended_queue_core_assert.svh"

module bounded_double_ended_queue_core #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // request stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [bdq_pkg::DATA_W-1:0]    s_tdata,   // [31:0] push_value
  input  logic [1:0]                    s_tuser,   // [1:0] action
  // result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [bdq_pkg::DATA_W-1:0]    m_tdata,   // [31:0] data_value
  output logic [2:0]                    m_tuser,   // [1:0] status, [2] at_right
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [1:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import bdq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [CAP_W-1:0]  capacity;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;

  logic [DEPTH-1:0][DATA_W-1:0] cell_val;
  logic [DEPTH-1:0][DATA_W-1:0] cell_tail;
  logic [DATA_W-1:0]            tail_word;

  logic              s_fire;
  logic              is_push;
  logic              at_right;
  logic              full;
  logic              empty;
  bdq_op_t           op;
  bdq_status_t       status_next;
  logic [DATA_W-1:0] data_next;

  // ---------------------------------------------------------------------
  // configuration port; one register at address 0, read back at any address
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = {{(32 - CAP_W){1'b0}}, capacity};

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_CAPACITY)) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // request decode
  // ---------------------------------------------------------------------
  assign s_tready = !m_tvalid || m_tready;
  assign s_fire   = s_tvalid && s_tready;
  assign is_push  = (s_tuser == ACT_PUSH_LEFT) || (s_tuser == ACT_PUSH_RIGHT);
  assign at_right = s_tuser[0];

  // limit is min(capacity, DEPTH): full at either bound
  assign full  = (LW'(count) >= LW'(capacity)) || (count == FULL_COUNT);
  assign empty = (count == '0);

  always_comb begin
    op.push_left  = s_fire && is_push && !full && !at_right;
    op.push_right = s_fire && is_push && !full && at_right;
    op.pop_left   = s_fire && !is_push && !empty && !at_right;
  end

  // pop-right tap: only the cell at count-1 drives a non-zero word
  always_comb begin
    tail_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_word = tail_word | cell_tail[i];
    end
  end

  always_comb begin
    count_next  = count;
    data_next   = '0;
    status_next = ST_EMPTY;
    if (is_push) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_PUSHED;
        data_next   = s_tdata;
        count_next  = count + CW'(1);
      end
    end else begin
      if (empty) begin
        status_next = ST_EMPTY;
      end else begin
        status_next = ST_POPPED;
        data_next   = at_right ? tail_word : cell_val[0];
        count_next  = count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (s_fire) begin
      count <= count_next;
    end
  end

  // ---------------------------------------------------------------------
  // the cell row
  // ---------------------------------------------------------------------
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] left_in;
    logic [DATA_W-1:0] right_in;

    if (g == 0) begin : g_first
      assign left_in = s_tdata;
    end else begin : g_mid
      assign left_in = cell_val[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_in = cell_val[g];
    end else begin : g_inner
      assign right_in = cell_val[g+1];
    end

    bdq_cell #(
      .CW  (CW),
      .IDX (g)
    ) u_cell (
      .clk        (clk),
      .op         (op),
      .count      (count),
      .push_value (s_tdata),
      .from_left  (left_in),
      .from_right (right_in),
      .value      (cell_val[g]),
      .tail_value (cell_tail[g])
    );
  end

  // ---------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      m_tdata <= data_next;
      m_tuser <= {at_right, status_next};
    end
  end

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  `BDQ_ASSERT(a_count_bound, clk, rst, count <= FULL_COUNT)
  `BDQ_ASSERT(a_push_grows, clk, rst,
    s_fire && is_push && !full |=> count == $past(count) + CW'(1))
  `BDQ_ASSERT(a_pop_shrinks, clk, rst,
    s_fire && !is_push && !empty |=> count == $past(count) - CW'(1))
  `BDQ_ASSERT(a_reject_zero, clk, rst,
    m_tvalid && ((m_tuser[1:0] == ST_FULL) || (m_tuser[1:0] == ST_EMPTY)) |-> m_tdata == '0)

endmodule

### rtl/bdq_cell.sv
module bdq_cell #(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic                          clk,
  input  bdq_pkg::bdq_op_t              op,
  input  logic [CW-1:0]                 count,
  input  logic [bdq_pkg::DATA_W-1:0]    push_value,
  input  logic [bdq_pkg::DATA_W-1:0]    from_left,
  input  logic [bdq_pkg::DATA_W-1:0]    from_right,
  output logic [bdq_pkg::DATA_W-1:0]    value,
  output logic [bdq_pkg::DATA_W-1:0]    tail_value
);
  import bdq_pkg::*;

  localparam logic [CW-1:0] MY_POS   = CW'(IDX);
  localparam logic [CW-1:0] NEXT_POS = CW'(IDX + 1);

  // push left shifts the row right, pop left shifts it left,
  // push right lands in the first free cell
  always_ff @(posedge clk) begin
    if (op.push_left) begin
      value <= from_left;
    end else if (op.pop_left) begin
      value <= from_right;
    end else if (op.push_right && (count == MY_POS)) begin
      value <= push_value;
    end
  end

  // rightmost occupied cell drives the pop-right bus
  assign tail_value = (count == NEXT_POS) ? value : '0;

endmodule
